/* hdl/nucleotide_encode_revcomp_assert.svh */
// Assertion macros for the nucleotide encoder
`ifndef NUCLEOTIDE_ENCODE_REVCOMP_ASSERT_SVH
`define NUCLEOTIDE_ENCODE_REVCOMP_ASSERT_SVH

// same-cycle implication, clocked on clk, disabled in reset
`define NER_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, disabled in reset
`define NER_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ner_pkg.sv */
// Types and constants shared by the nucleotide encoder modules
package ner_pkg;

    localparam int MAX_LEN       = 256;
    localparam int ADDR_W        = $clog2(MAX_LEN);
    localparam int CNT_W         = $clog2(MAX_LEN + 1);
    localparam int SYM_W         = 3;
    localparam int SYMS_PER_ITEM = 8;
    localparam int SLOT_W        = $clog2(SYMS_PER_ITEM);
    localparam int PACK_W        = SYM_W * SYMS_PER_ITEM;
    localparam int SEQ_LEN_W     = 9;
    localparam int SYM_CNT_W     = 4;
    localparam int REG_IDX_W     = 2;

    localparam logic [REG_IDX_W-1:0] REG_EMIT_FORWARD    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_EMIT_REVERSE    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TRIM_PALINDROME = 2'd2;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_seq;
    } in_item_t;

    typedef struct packed {
        logic [PACK_W-1:0]    symbols;
        logic [SYM_CNT_W-1:0] sym_count;
        logic                 strand;
        logic [SEQ_LEN_W-1:0] seq_length;
        logic                 last;
        logic                 truncated;
    } res_item_t;

    typedef struct packed {
        logic emit_forward;
        logic emit_reverse;
        logic trim_palindrome;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [SYM_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } mem_req_t;

endpackage

/* hdl/ner_ram.sv */
// Symbol buffer: one write port, two registered read ports
module ner_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 3
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* hdl/ner_seq.sv */
// Sequencer: loads symbols, runs the pair check and packs the enabled strands
module ner_seq import ner_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             start,
    input  in_item_t         item,
    output logic             busy,
    output mem_req_t         mem_req,
    input  logic [SYM_W-1:0] rdata_a,
    input  logic [SYM_W-1:0] rdata_b,
    output logic             result_valid,
    output res_item_t        result
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_CHECK,
        S_SELECT,
        S_EMIT,
        S_DRAIN
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              strand_reg, strand_next;
    logic              fail_reg, fail_next;
    logic              chk_vld_reg, chk_vld_next;
    logic              emt_vld_reg, emt_vld_next;
    logic              rd_strand_reg, rd_strand_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic              rd_end_reg, rd_end_next;
    logic [PACK_W-1:0] pack_reg, pack_next;
    logic              res_vld_reg, res_vld_next;
    res_item_t         res_reg, res_next;

    logic              accept;
    logic [CNT_W-1:0]  fill_after;
    logic [CNT_W-1:0]  half;
    logic [CNT_W-1:0]  mirror;
    logic [CNT_W-1:0]  emit_addr;
    logic [SYM_W-1:0]  sym;
    logic [PACK_W-1:0] pack_cur;

    function automatic logic [SYM_W-1:0] encode(input logic [7:0] c);
        logic [SYM_W-1:0] s;
        case (c) inside
            8'h00:        s = 3'd0;
            8'h41, 8'h61: s = 3'd1;
            8'h43, 8'h63: s = 3'd2;
            8'h47, 8'h67: s = 3'd3;
            8'h54, 8'h74: s = 3'd4;
            default:      s = 3'd5;
        endcase
        return s;
    endfunction

    function automatic logic [SYM_W-1:0] complement(input logic [SYM_W-1:0] x);
        logic [SYM_W-1:0] s;
        if (x >= 3'd1 && x <= 3'd4)
        begin
            s = 3'd5 - x;
        end
        else
        begin
            s = x;
        end
        return s;
    endfunction

    assign busy       = (state_reg != S_LOAD);
    assign accept     = start && !busy;
    assign fill_after = (fill_reg < CNT_W'(MAX_LEN)) ? fill_reg + 1'b1 : fill_reg;
    assign half       = len_reg >> 1;
    assign mirror     = len_reg - 1'b1 - idx_reg;
    assign emit_addr  = strand_reg ? mirror : idx_reg;
    assign sym        = rd_strand_reg ? complement(rdata_a) : rdata_a;
    assign pack_cur   = pack_reg | (PACK_W'(sym) << (SYM_W * rd_slot_reg));

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        strand_next    = strand_reg;
        fail_next      = fail_reg;
        chk_vld_next   = 1'b0;
        emt_vld_next   = 1'b0;
        rd_strand_next = rd_strand_reg;
        rd_slot_next   = rd_slot_reg;
        rd_end_next    = rd_end_reg;
        pack_next      = pack_reg;
        res_vld_next   = 1'b0;
        res_next       = res_reg;

        mem_req.we      = 1'b0;
        mem_req.waddr   = fill_reg[ADDR_W-1:0];
        mem_req.wdata   = encode(item.char_in);
        mem_req.raddr_a = idx_reg[ADDR_W-1:0];
        mem_req.raddr_b = mirror[ADDR_W-1:0];

        // results from reads issued in the previous cycle
        if (emt_vld_reg)
        begin
            res_next.symbols    = pack_cur;
            res_next.sym_count  = SYM_CNT_W'(rd_slot_reg) + 1'b1;
            res_next.strand     = rd_strand_reg;
            res_next.seq_length = SEQ_LEN_W'(len_reg);
            res_next.last       = rd_end_reg && (rd_strand_reg || !cfg.emit_reverse);
            res_next.truncated  = ovf_reg;
            if (rd_end_reg || rd_slot_reg == SLOT_W'(SYMS_PER_ITEM - 1))
            begin
                res_vld_next = 1'b1;
                pack_next    = '0;
            end
            else
            begin
                pack_next = pack_cur;
            end
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (fill_reg < CNT_W'(MAX_LEN))
                    begin
                        mem_req.we = 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    fill_next = fill_after;
                    if (item.end_of_seq)
                    begin
                        len_next  = fill_after;
                        idx_next  = '0;
                        fail_next = 1'b0;
                        if (cfg.trim_palindrome && !fill_after[0] && fill_after >= CNT_W'(2))
                        begin
                            state_next = S_CHECK;
                        end
                        else
                        begin
                            state_next = S_SELECT;
                        end
                    end
                end
            end
            S_CHECK:
            begin
                if (chk_vld_reg && ({1'b0, rdata_a} + {1'b0, rdata_b} != 4'd5))
                begin
                    fail_next = 1'b1;
                end
                if (idx_reg < half)
                begin
                    chk_vld_next = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                end
                else if (!chk_vld_reg)
                begin
                    if (!fail_reg)
                    begin
                        len_next = len_reg - 1'b1;
                    end
                    state_next = S_SELECT;
                end
            end
            S_SELECT:
            begin
                idx_next  = '0;
                pack_next = '0;
                if (cfg.emit_forward)
                begin
                    strand_next = 1'b0;
                    state_next  = S_EMIT;
                end
                else if (cfg.emit_reverse)
                begin
                    strand_next = 1'b1;
                    state_next  = S_EMIT;
                end
                else
                begin
                    fill_next  = '0;
                    ovf_next   = 1'b0;
                    state_next = S_LOAD;
                end
            end
            S_EMIT:
            begin
                mem_req.raddr_a = emit_addr[ADDR_W-1:0];
                emt_vld_next    = 1'b1;
                rd_strand_next  = strand_reg;
                rd_slot_next    = idx_reg[SLOT_W-1:0];
                rd_end_next     = (idx_reg == len_reg - 1'b1);
                idx_next        = idx_reg + 1'b1;
                if (idx_reg == len_reg - 1'b1)
                begin
                    idx_next = '0;
                    if (!strand_reg && cfg.emit_reverse)
                    begin
                        strand_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                fill_next  = '0;
                ovf_next   = 1'b0;
                state_next = S_LOAD;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            fill_reg    <= '0;
            ovf_reg     <= 1'b0;
            chk_vld_reg <= 1'b0;
            emt_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            ovf_reg     <= ovf_next;
            chk_vld_reg <= chk_vld_next;
            emt_vld_reg <= emt_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg       <= len_next;
        idx_reg       <= idx_next;
        strand_reg    <= strand_next;
        fail_reg      <= fail_next;
        rd_strand_reg <= rd_strand_next;
        rd_slot_reg   <= rd_slot_next;
        rd_end_reg    <= rd_end_next;
        pack_reg      <= pack_next;
        res_reg       <= res_next;
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

endmodule

/* hdl/nucleotide_encode_revcomp.sv */
// Top level of the nucleotide encoder with reverse complement output
//
// One character item is taken per cycle while busy is low; each is encoded and
// written to the symbol buffer in that cycle, or dropped once the buffer is full.
// The end-of-sequence item raises busy: with trimming on and an even length of at
// least two, the pair check reads one symbol pair per cycle from the two buffer
// read ports, then each enabled strand is read one symbol per cycle, with a
// select state before them and a drain state after. A result appears every eight
// symbols for one cycle on result_valid and must be taken then; the block cannot
// be stalled. Register writes are meant for idle periods.
`include "nucleotide_encode_revcomp_assert.svh"

module nucleotide_encode_revcomp import ner_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  in_item_t             item,
    output logic                 busy,
    output logic                 result_valid,
    output res_item_t            result,
    input  logic                 wr_en,
    input  logic [REG_IDX_W-1:0] wr_index,
    input  logic                 wr_data
);

    cfg_t             cfg_reg, cfg_next;
    mem_req_t         mem_req;
    logic [SYM_W-1:0] rdata_a;
    logic [SYM_W-1:0] rdata_b;
    logic             take_mid;
    logic             count_ok;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_EMIT_FORWARD:    cfg_next.emit_forward    = wr_data;
                REG_EMIT_REVERSE:    cfg_next.emit_reverse    = wr_data;
                REG_TRIM_PALINDROME: cfg_next.trim_palindrome = wr_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{emit_forward: 1'b1, emit_reverse: 1'b1, trim_palindrome: 1'b1};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ner_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .mem_req      (mem_req),
        .rdata_a      (rdata_a),
        .rdata_b      (rdata_b),
        .result_valid (result_valid),
        .result       (result)
    );

    ner_ram #(
        .DEPTH (MAX_LEN),
        .WIDTH (SYM_W)
    ) u_ram (
        .clk     (clk),
        .we      (mem_req.we),
        .waddr   (mem_req.waddr),
        .wdata   (mem_req.wdata),
        .raddr_a (mem_req.raddr_a),
        .raddr_b (mem_req.raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign take_mid = start && !busy && !item.end_of_seq;
    assign count_ok = (result.sym_count != 4'd0) && (result.sym_count <= 4'd8);

    `NER_ASSERT_NXT(a_no_result_mid_seq, take_mid, !result_valid, "result after a non-final item")
    `NER_ASSERT_IMP(a_result_in_busy, result_valid, $past(busy), "result while idle")
    `NER_ASSERT_IMP(a_last_ends_busy, result_valid && result.last, !busy, "busy after last result")
    `NER_ASSERT_IMP(a_count_range, result_valid, count_ok, "symbol count out of range")

endmodule

/* test/ner_strand_checker.sv */
// Scoreboard for the nucleotide encoder: predicts packed strand results and checks them
module ner_strand_checker
    import ner_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  in_item_t             item,
    input  logic                 result_valid,
    input  res_item_t            result,
    input  logic                 wr_en,
    input  logic [REG_IDX_W-1:0] wr_index,
    input  logic                 wr_data,
    output int                   errors,
    output int                   pending,
    output int                   results_seen,
    output int                   seqs_seen,
    output int                   trims_seen,
    output int                   truncs_seen
);

    localparam logic [SYM_W-1:0] SYM_NUL   = 3'd0;
    localparam logic [SYM_W-1:0] SYM_A     = 3'd1;
    localparam logic [SYM_W-1:0] SYM_C     = 3'd2;
    localparam logic [SYM_W-1:0] SYM_G     = 3'd3;
    localparam logic [SYM_W-1:0] SYM_T     = 3'd4;
    localparam logic [SYM_W-1:0] SYM_OTHER = 3'd5;
    localparam logic [SYM_W-1:0] PAIR_SUM  = SYM_A + SYM_T;

    logic [SYM_W-1:0] sym_store [MAX_LEN];
    int               fill_len;
    logic             dropped;
    cfg_t             cfg;
    res_item_t        strand_words_q [$];
    int               n_err;
    int               n_res;
    int               n_seq;
    int               n_trim;
    int               n_trunc;

    function automatic logic [SYM_W-1:0] encode_sym(input logic [7:0] ch);
        case (ch)
            8'h00:    return SYM_NUL;
            "A", "a": return SYM_A;
            "C", "c": return SYM_C;
            "G", "g": return SYM_G;
            "T", "t": return SYM_T;
            default:  return SYM_OTHER;
        endcase
    endfunction

    function automatic logic [SYM_W-1:0] mate_sym(input logic [SYM_W-1:0] s);
        if (s >= SYM_A && s <= SYM_T)
            return PAIR_SUM - s;
        return s;
    endfunction

    task automatic flag_result(input string why, input res_item_t exp_w, input res_item_t got_w);
        n_err++;
        if (n_err <= 10)
        begin
            $display("ERROR @%0t: %s", $time, why);
            $display("  exp sym=%06h cnt=%0d strand=%0d len=%0d last=%0d trunc=%0d",
                     exp_w.symbols, exp_w.sym_count, exp_w.strand, exp_w.seq_length,
                     exp_w.last, exp_w.truncated);
            $display("  got sym=%06h cnt=%0d strand=%0d len=%0d last=%0d trunc=%0d",
                     got_w.symbols, got_w.sym_count, got_w.strand, got_w.seq_length,
                     got_w.last, got_w.truncated);
        end
    endtask

    // store one character; on end of sequence queue up the packed strands
    task automatic predict_strands(input logic [7:0] ch, input logic eos);
        int        len;
        int        i;
        int        j;
        int        s;
        int        pos;
        int        cnt;
        int        nwords;
        int        k;
        bit        pal;
        res_item_t w;

        if (fill_len < MAX_LEN)
        begin
            sym_store[fill_len] = encode_sym(ch);
            fill_len++;
        end
        else
            dropped = 1'b1;
        if (!eos)
            return;

        len = fill_len;
        if (cfg.trim_palindrome && (len % 2) == 0 && len >= 2)
        begin
            pal = 1'b1;
            for (i = 0; i < len / 2; i++)
                if (int'(sym_store[i]) + int'(sym_store[len - 1 - i]) != int'(PAIR_SUM))
                    pal = 1'b0;
            if (pal)
            begin
                len--;
                n_trim++;
            end
        end

        nwords = (int'(cfg.emit_forward) + int'(cfg.emit_reverse)) * ((len + 7) / 8);
        k = 0;
        for (s = 0; s < 2; s++)
        begin
            if ((s == 0 && cfg.emit_forward) || (s == 1 && cfg.emit_reverse))
            begin
                for (pos = 0; pos < len; pos += SYMS_PER_ITEM)
                begin
                    cnt = (len - pos > SYMS_PER_ITEM) ? SYMS_PER_ITEM : len - pos;
                    w = '0;
                    for (j = 0; j < cnt; j++)
                        w.symbols[SYM_W*j +: SYM_W] = (s == 0) ? sym_store[pos + j]
                                                     : mate_sym(sym_store[len - 1 - pos - j]);
                    w.sym_count  = SYM_CNT_W'(cnt);
                    w.strand     = (s == 1);
                    w.seq_length = SEQ_LEN_W'(len);
                    w.last       = (k == nwords - 1);
                    w.truncated  = dropped;
                    strand_words_q.push_back(w);
                    k++;
                end
            end
        end

        n_seq++;
        if (dropped)
            n_trunc++;
        fill_len = 0;
        dropped  = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_len = 0;
            dropped  = 1'b0;
            cfg      = '1;
            strand_words_q.delete();
            n_err    = 0;
            n_res    = 0;
            n_seq    = 0;
            n_trim   = 0;
            n_trunc  = 0;
            errors       <= 0;
            pending      <= 0;
            results_seen <= 0;
            seqs_seen    <= 0;
            trims_seen   <= 0;
            truncs_seen  <= 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_EMIT_FORWARD:    cfg.emit_forward    = wr_data;
                    REG_EMIT_REVERSE:    cfg.emit_reverse    = wr_data;
                    REG_TRIM_PALINDROME: cfg.trim_palindrome = wr_data;
                    default: ;
                endcase
            end

            if (result_valid)
            begin
                n_res++;
                if (strand_words_q.size() == 0)
                    flag_result("result with nothing expected", '0, result);
                else
                begin
                    res_item_t exp_w;
                    exp_w = strand_words_q.pop_front();
                    if (result.symbols    !== exp_w.symbols    ||
                        result.sym_count  !== exp_w.sym_count  ||
                        result.strand     !== exp_w.strand     ||
                        result.seq_length !== exp_w.seq_length ||
                        result.last       !== exp_w.last       ||
                        result.truncated  !== exp_w.truncated)
                        flag_result("result field differs", exp_w, result);
                end
            end

            if (start && !busy)
                predict_strands(item.char_in, item.end_of_seq);

            errors       <= n_err;
            pending      <= strand_words_q.size();
            results_seen <= n_res;
            seqs_seen    <= n_seq;
            trims_seen   <= n_trim;
            truncs_seen  <= n_trunc;
        end
    end

endmodule

/* test/tb_nucleotide_encode_revcomp.sv */
// Testbench top for the nucleotide encoder: stimulus, register settings and verdict
module tb_nucleotide_encode_revcomp;
    import ner_pkg::*;

    localparam int LIMIT = 400000;
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum int {SEQ_RANDOM, SEQ_PALIN, SEQ_NEAR, SEQ_NOISE} seq_kind_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    in_item_t             item;
    logic                 busy;
    logic                 result_valid;
    res_item_t            result;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] wr_index;
    logic                 wr_data;

    int errors;
    int pending;
    int results_seen;
    int seqs_seen;
    int trims_seen;
    int truncs_seen;

    int         cycles = 0;
    int         items_sent = 0;
    int         idle_pct = 0;
    logic [7:0] seq_chars [0:MAX_LEN+2];

    nucleotide_encode_revcomp dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    ner_strand_checker strand_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen),
        .seqs_seen    (seqs_seen),
        .trims_seen   (trims_seen),
        .truncs_seen  (truncs_seen)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("TIMEOUT after %0d cycles, %0d results outstanding", cycles, pending);
            $display("nucleotide_encode_revcomp: mismatch");
            $finish;
        end
    end

    function automatic logic [7:0] any_case(input logic [7:0] up);
        return $urandom_range(0, 1) ? up : (up | 8'h20);
    endfunction

    function automatic bit is_base(input logic [7:0] ch);
        logic [7:0] up;
        up = ch & 8'hDF;
        return up == "A" || up == "C" || up == "G" || up == "T";
    endfunction

    function automatic logic [7:0] other_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (is_base(b));
        return b;
    endfunction

    function automatic logic [7:0] base_char();
        case ($urandom_range(0, 3))
            0:       return any_case("A");
            1:       return any_case("C");
            2:       return any_case("G");
            default: return any_case("T");
        endcase
    endfunction

    function automatic logic [7:0] random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return base_char();
        if (r < 75)
            return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // partner that makes the pair self-complementary
    function automatic logic [7:0] mate_char(input logic [7:0] ch);
        case (ch)
            "A", "a": return any_case("T");
            "T", "t": return any_case("A");
            "C", "c": return any_case("G");
            "G", "g": return any_case("C");
            8'h00:    return other_char();
            default:  return 8'h00;
        endcase
    endfunction

    task automatic make_seq(input seq_kind_t kind, input int n);
        int i;
        case (kind)
            SEQ_RANDOM:
                for (i = 0; i < n; i++)
                    seq_chars[i] = random_char();
            SEQ_NOISE:
                for (i = 0; i < n; i++)
                    seq_chars[i] = 8'($urandom_range(0, 255));
            default:
            begin
                for (i = 0; i < n / 2; i++)
                begin
                    seq_chars[i] = random_char();
                    seq_chars[n - 1 - i] = mate_char(seq_chars[i]);
                end
                if (kind == SEQ_NEAR)
                    seq_chars[$urandom_range(0, n - 1)] = random_char();
            end
        endcase
    endtask

    task automatic send_item(input logic [7:0] ch, input logic eos);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= in_item_t'{char_in: ch, end_of_seq: eos};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_seq(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_item(seq_chars[i], i == n - 1);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(s[i], i == s.len() - 1);
    endtask

    // quiet point: all results in and the block no longer busy
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_config(input logic fwd, input logic rev, input logic trim);
        wait_idle();
        write_reg(REG_EMIT_FORWARD, fwd);
        write_reg(REG_EMIT_REVERSE, rev);
        write_reg(REG_TRIM_PALINDROME, trim);
        write_reg(REG_SPARE, 1'($urandom_range(0, 1)));
        wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic fwd, input logic rev, input logic trim,
                             input int pct, input int n_items);
        int stop_at;
        int pick;
        int n;
        set_config(fwd, rev, trim);
        idle_pct = pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 16);
            if (pick < 40)
                make_seq(SEQ_RANDOM, n);
            else if (pick < 88)
            begin
                n = 2 * ((n + 1) / 2);
                make_seq(pick < 75 ? SEQ_PALIN : SEQ_NEAR, n);
            end
            else
                make_seq(SEQ_NOISE, n);
            send_seq(n);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        item     = '0;
        wr_en    = 1'b0;
        wr_index = '0;
        wr_data  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single symbol, short palindromes, NUL/other pair, byte extremes
        send_text("A");
        send_text("AT");
        seq_chars[0] = 8'h00;
        seq_chars[1] = "X";
        send_seq(2);
        send_text("acgt");
        seq_chars[0] = 8'hFF;
        seq_chars[1] = 8'h80;
        seq_chars[2] = 8'h7F;
        seq_chars[3] = 8'h00;
        seq_chars[4] = "g";
        send_seq(5);
        send_text("GATTACAGC");

        // buffer capacity: full palindrome, end character dropped on overflow
        set_config(1'b1, 1'b1, 1'b1);
        make_seq(SEQ_PALIN, MAX_LEN);
        seq_chars[MAX_LEN] = random_char();
        send_seq(MAX_LEN + 1);

        run_phase(1'b1, 1'b1, 1'b1, 0, 10);
        run_phase(1'b1, 1'b0, 1'b1, 73, 10);
        run_phase(1'b0, 1'b1, 1'b0, 6, 10);
        run_phase(1'b0, 1'b0, 1'b1, 0, 10);
        run_phase(1'b1, 1'b1, 1'b0, 73, 10);
        run_phase(1'b1, 1'b1, 1'b1, 6, 10);

        wait_idle();
        repeat (32) @(posedge clk);

        $display("Sent %0d items in %0d sequences over five register settings, idle 0/6/73%%.",
                 items_sent, seqs_seen);
        $display("Checked %0d results: %0d trimmed, %0d truncated, %0d errors, %0d missing.",
                 results_seen, trims_seen, truncs_seen, errors, pending);
        if (errors == 0 && pending == 0)
            $display("nucleotide_encode_revcomp: match");
        else
            $display("nucleotide_encode_revcomp: mismatch");
        $finish;
    end

endmodule
